FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files of this project.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled during reset.
`define SST_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sst assertion failed");

// Next-cycle implication, disabled during reset.
`define SST_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sst assertion failed");

// Next-cycle implication that is checked through reset as well.
`define SST_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sst assertion failed");

`endif

FILE: rtl/sst_pkg.sv
// Shared types, token codes and character-class functions of the tokenizer.
// No dependencies; used by the scanner, the result queue, the top level and the checker.
package sst_pkg;

   localparam int unsigned POSITION_BITS_DEF = 16;
   localparam int unsigned MAX_RESULTS = 3;

   typedef logic [4:0] kind_type;

   localparam kind_type KIND_NUM     = 5'd0;
   localparam kind_type KIND_ID      = 5'd1;
   localparam kind_type KIND_KW_INT  = 5'd2;
   localparam kind_type KIND_STRLIT  = 5'd5;
   localparam kind_type KIND_NEWLINE = 5'd6;
   localparam kind_type KIND_EQUAL   = 5'd7;
   localparam kind_type KIND_SEMI    = 5'd8;
   localparam kind_type KIND_LPAREN  = 5'd9;
   localparam kind_type KIND_RPAREN  = 5'd10;
   localparam kind_type KIND_LESS    = 5'd11;
   localparam kind_type KIND_GREATER = 5'd12;
   localparam kind_type KIND_SLASH   = 5'd13;
   localparam kind_type KIND_BSLASH  = 5'd14;
   localparam kind_type KIND_PLUS    = 5'd15;
   localparam kind_type KIND_MINUS   = 5'd16;
   localparam kind_type KIND_STAR    = 5'd17;
   localparam kind_type KIND_END     = 5'd18;
   localparam kind_type KIND_BAD     = 5'd19;
   localparam kind_type KIND_UNTERM  = 5'd20;

   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_NUL     = 8'h00;

   localparam logic [15:0] FIELD_MAX = 16'hFFFF;

   // Keyword spellings: int, string, sout.  Rows are padded with NUL.
   localparam logic [7:0] KW_TEXT [3][8] = '{
      '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
      '{"s", "o", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00}
   };
   localparam logic [15:0] KW_LEN [3] = '{16'd3, 16'd6, 16'd4};

   typedef struct packed {
      kind_type    kind;
      logic [15:0] start;
      logic [15:0] length;
      logic        last;
   } token_rec_type;

   typedef struct packed {
      logic                                load;
      logic [1:0]                          count;
      token_rec_type [MAX_RESULTS-1:0]     rec;
   } scan_load_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   // Space, TAB, VT, FF and CR.
   function automatic logic is_blank(input logic [7:0] c);
      return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
   endfunction

   // Kind of a one-byte punctuator; a byte that is no punctuator maps to KIND_BAD.
   function automatic kind_type punct_kind(input logic [7:0] c);
      kind_type k;
      unique case (c)
         "=":     k = KIND_EQUAL;
         ";":     k = KIND_SEMI;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "<":     k = KIND_LESS;
         ">":     k = KIND_GREATER;
         "/":     k = KIND_SLASH;
         8'h5C:   k = KIND_BSLASH;
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         default: k = KIND_BAD;
      endcase
      return k;
   endfunction

   // Drops every keyword that the character at offset plen rules out.
   function automatic logic [2:0] kw_track(input logic [2:0] kc, input logic [15:0] plen,
                                           input logic [7:0] c);
      logic [2:0] r;
      r = kc;
      for (int k = 0; k < 3; k++) begin
         if (kc[k] && ((plen >= KW_LEN[k]) || (KW_TEXT[k][plen[2:0]] != c))) begin
            r[k] = 1'b0;
         end
      end
      return r;
   endfunction

   function automatic kind_type id_kind(input logic [2:0] kc, input logic [15:0] plen);
      kind_type k;
      k = KIND_ID;
      for (int i = 0; i < 3; i++) begin
         if (kc[i] && (plen == KW_LEN[i])) begin
            k = KIND_KW_INT + kind_type'(i);
         end
      end
      return k;
   endfunction

   function automatic logic [15:0] len_inc(input logic [15:0] x);
      return (x == FIELD_MAX) ? x : x + 16'd1;
   endfunction

endpackage

FILE: rtl/sst_req_if.sv
// Input channel of the tokenizer: one source byte per transaction.
// No dependencies.
interface sst_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       is_final;

   modport source (output valid, output text_byte, output is_final, input ready);
   modport sink   (input valid, input text_byte, input is_final, output ready);
endinterface

FILE: rtl/sst_rsp_if.sv
// Result channel of the tokenizer: one token record per transaction.
// No dependencies.
interface sst_rsp_if;
   logic        valid;
   logic        ready;
   logic [4:0]  token_kind;
   logic [15:0] token_start;
   logic [15:0] token_length;
   logic        run_last;

   modport source (output valid, output token_kind, output token_start, output token_length,
                   output run_last, input ready);
   modport sink   (input valid, input token_kind, input token_start, input token_length,
                   input run_last, output ready);
endinterface

FILE: rtl/sst_scan.sv
// Scanner state and the single-pass logic that turns one byte into up to three records.
// Depends on sst_pkg.
module sst_scan #(
   parameter int unsigned POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            text_byte,
   input  logic                  is_final,
   output sst_pkg::scan_load_type load
);
   import sst_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NUM,
      MODE_ID,
      MODE_STR,
      MODE_HALT
   } mode_type;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   mode_type                 mode_ff, mode_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [15:0]              pstart_ff, pstart_in;
   logic [15:0]              plen_ff, plen_in;
   logic [2:0]               kc_ff, kc_in;

   logic [32:0]              pos_w;
   logic [32:0]              pos1_w;
   logic [15:0]              pos16;
   logic [15:0]              pos16_next;
   token_rec_type [MAX_RESULTS-1:0] rec_c;
   logic [1:0]               n_c;
   logic                     idle_go;
   kind_type                 pk;

   function automatic token_rec_type mk(input kind_type k, input logic [15:0] s,
                                        input logic [15:0] l);
      token_rec_type r;
      r.kind   = k;
      r.start  = s;
      r.length = l;
      r.last   = 1'b0;
      return r;
   endfunction

   // Offsets go out on 16 bits and stick at the top instead of wrapping.
   assign pos_w      = 33'(pos_ff);
   assign pos1_w     = pos_w + 33'd1;
   assign pos16      = (pos_w  > 33'h0FFFF) ? FIELD_MAX : pos_w[15:0];
   assign pos16_next = (pos1_w > 33'h0FFFF) ? FIELD_MAX : pos1_w[15:0];
   assign pk         = punct_kind(text_byte);

   always_comb begin
      mode_in   = mode_ff;
      pos_in    = pos_ff;
      pstart_in = pstart_ff;
      plen_in   = plen_ff;
      kc_in     = kc_ff;
      rec_c     = '0;
      n_c       = 2'd0;
      idle_go   = 1'b0;

      unique case (mode_ff)
         MODE_NUM: begin
            if (is_digit(text_byte)) begin
               plen_in = len_inc(plen_ff);
            end else begin
               rec_c[n_c] = mk(KIND_NUM, pstart_ff, plen_ff);
               n_c        = n_c + 2'd1;
               mode_in    = MODE_IDLE;
               idle_go    = 1'b1;
            end
         end
         MODE_ID: begin
            if (is_digit(text_byte) || is_alpha(text_byte)) begin
               kc_in   = kw_track(kc_ff, plen_ff, text_byte);
               plen_in = len_inc(plen_ff);
            end else begin
               rec_c[n_c] = mk(id_kind(kc_ff, plen_ff), pstart_ff, plen_ff);
               n_c        = n_c + 2'd1;
               mode_in    = MODE_IDLE;
               idle_go    = 1'b1;
            end
         end
         MODE_STR: begin
            priority if (text_byte == CH_QUOTE) begin
               rec_c[n_c] = mk(KIND_STRLIT, pstart_ff, plen_ff);
               n_c        = n_c + 2'd1;
               mode_in    = MODE_IDLE;
            end else if (text_byte == CH_NUL) begin
               rec_c[n_c] = mk(KIND_UNTERM, pstart_ff, plen_ff);
               n_c        = n_c + 2'd1;
               rec_c[n_c] = mk(KIND_END, pos16, 16'd0);
               n_c        = n_c + 2'd1;
               mode_in    = MODE_HALT;
            end else begin
               plen_in = len_inc(plen_ff);
            end
         end
         MODE_IDLE: begin
            idle_go = 1'b1;
         end
         default: begin
            mode_in = MODE_HALT;
         end
      endcase

      // A byte that ends a number or identifier is scanned again as a fresh byte.
      if (idle_go) begin
         priority if (is_blank(text_byte)) begin
            mode_in = MODE_IDLE;
         end else if (is_digit(text_byte)) begin
            mode_in   = MODE_NUM;
            pstart_in = pos16;
            plen_in   = 16'd1;
         end else if (is_alpha(text_byte)) begin
            mode_in   = MODE_ID;
            pstart_in = pos16;
            plen_in   = 16'd1;
            kc_in     = kw_track(3'b111, 16'd0, text_byte);
         end else if (text_byte == CH_QUOTE) begin
            mode_in   = MODE_STR;
            pstart_in = pos16_next;
            plen_in   = 16'd0;
         end else if (text_byte == CH_NEWLINE) begin
            rec_c[n_c] = mk(KIND_NEWLINE, pos16, 16'd1);
            n_c        = n_c + 2'd1;
         end else if (text_byte == CH_NUL) begin
            rec_c[n_c] = mk(KIND_END, pos16, 16'd0);
            n_c        = n_c + 2'd1;
            mode_in    = MODE_HALT;
         end else begin
            rec_c[n_c] = mk(pk, pos16, 16'd1);
            n_c        = n_c + 2'd1;
            if (pk == KIND_BAD) begin
               mode_in = MODE_HALT;
            end
         end
      end

      if (is_final) begin
         priority if (mode_in == MODE_NUM) begin
            rec_c[n_c] = mk(KIND_NUM, pstart_in, plen_in);
            n_c        = n_c + 2'd1;
         end else if (mode_in == MODE_ID) begin
            rec_c[n_c] = mk(id_kind(kc_in, plen_in), pstart_in, plen_in);
            n_c        = n_c + 2'd1;
         end else if (mode_in == MODE_STR) begin
            rec_c[n_c] = mk(KIND_UNTERM, pstart_in, plen_in);
            n_c        = n_c + 2'd1;
         end else begin
            n_c = n_c;
         end
         if (mode_in != MODE_HALT) begin
            rec_c[n_c] = mk(KIND_END, pos16, 16'd0);
            n_c        = n_c + 2'd1;
         end
         mode_in   = MODE_IDLE;
         pos_in    = '0;
         pstart_in = 16'd0;
         plen_in   = 16'd0;
         kc_in     = 3'b111;
      end else if (pos_ff != POS_MAX) begin
         pos_in = pos_ff + POSITION_BITS'(1);
      end

      for (int i = 0; i < MAX_RESULTS; i++) begin
         rec_c[i].last = (2'(i) == (n_c - 2'd1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         pos_ff    <= '0;
         pstart_ff <= 16'd0;
         plen_ff   <= 16'd0;
         kc_ff     <= 3'b111;
      end else if (accept) begin
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         pstart_ff <= pstart_in;
         plen_ff   <= plen_in;
         kc_ff     <= kc_in;
      end
   end

   assign load.load  = accept;
   assign load.count = n_c;
   assign load.rec   = rec_c;

endmodule

FILE: rtl/sst_rspq.sv
// Result register bank: holds the records of one byte and hands them out one per transaction.
// Depends on sst_pkg.
module sst_rspq (
   input  logic                   clock,
   input  logic                   reset,
   input  sst_pkg::scan_load_type load,
   input  logic                   rsp_ready,
   output logic                   can_load,
   output logic                   rsp_valid,
   output sst_pkg::token_rec_type rsp_rec
);
   import sst_pkg::*;

   logic [1:0]                      cnt_ff, cnt_in;
   token_rec_type [MAX_RESULTS-1:0] buf_ff, buf_in;
   logic                            pop;

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_rec   = buf_ff[0];
   assign pop       = rsp_valid && rsp_ready;
   // A new byte may enter when the bank is empty or its last record leaves this cycle.
   assign can_load  = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);

   always_comb begin
      cnt_in = cnt_ff;
      buf_in = buf_ff;
      if (load.load) begin
         cnt_in = load.count;
         buf_in = load.rec;
      end else if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

FILE: rtl/source_text_tokenizer.sv
// Byte-serial source text tokenizer.  One byte of text is taken per req_ch transaction and
// scanned in the same cycle; the records it produces (none, one, two or three) are loaded
// into a three-entry result bank and leave one per rsp_ch transaction, each with run_last
// set on the final record of its byte.  While rsp_ch is ready, text whose bytes yield at
// most one record each streams at one byte per cycle; a byte that yields more records
// holds the input until all but its last record have left, because the single result port
// drains the bank one record per cycle while rsp_ch is ready and the next byte enters while
// the last record is being taken.  A NUL or an unknown byte halts the text until the byte
// marked is_final, after which offsets restart at zero.  Offsets and lengths saturate at 65535.
// Depends on sst_pkg, sst_req_if, sst_rsp_if, sst_scan and sst_rspq.
module source_text_tokenizer #(
   parameter int unsigned POSITION_BITS = sst_pkg::POSITION_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   sst_req_if.sink       req_ch,
   sst_rsp_if.source     rsp_ch
);
   import sst_pkg::*;

   scan_load_type load;
   token_rec_type rsp_rec;
   logic          can_load;
   logic          accept;

   assign req_ch.ready = can_load;
   assign accept       = req_ch.valid && can_load;

   sst_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_ch.text_byte),
      .is_final  (req_ch.is_final),
      .load      (load)
   );

   sst_rspq u_rspq (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .rsp_ready (rsp_ch.ready),
      .can_load  (can_load),
      .rsp_valid (rsp_ch.valid),
      .rsp_rec   (rsp_rec)
   );

   assign rsp_ch.token_kind   = rsp_rec.kind;
   assign rsp_ch.token_start  = rsp_rec.start;
   assign rsp_ch.token_length = rsp_rec.length;
   assign rsp_ch.run_last     = rsp_rec.last;

endmodule

FILE: rtl/sst_checker.sv
// Port-level checks of the tokenizer, attached to the top level by a bind statement.
// Depends on sst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sst_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [4:0]  token_kind,
   input logic [15:0] token_start,
   input logic [15:0] token_length,
   input logic        run_last
);
   import sst_pkg::*;

   // A record waiting on the sink must not change.
   `SST_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(token_kind) && $stable(token_start) &&
      $stable(token_length) && $stable(run_last))

   // The input only stalls while records of an earlier byte are still pending.
   `SST_ASSERT_IMPL(a_stall_has_rsp, clock, reset, !req_ready, rsp_valid)

   // End of text is always the final record of its byte and has no length.
   `SST_ASSERT_IMPL(a_end_last, clock, reset, rsp_valid && (token_kind == KIND_END),
      run_last && (token_length == 16'd0))

   // Reset empties the result bank.
   `SST_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid)

endmodule

bind source_text_tokenizer sst_checker u_sst_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .token_kind   (rsp_ch.token_kind),
   .token_start  (rsp_ch.token_start),
   .token_length (rsp_ch.token_length),
   .run_last     (rsp_ch.run_last)
);
